FILE: src/nco_pkg.sv
// Shared types, constants and the quarter-wave sine table of the wave generator.
package nco_pkg;

  // Accumulator and table geometry.
  localparam int PhaseBits    = 32;
  localparam int SineAddrBits = 10;
  localparam int SineDepth    = 2 ** SineAddrBits;

  // Sample and magnitude widths.
  localparam int SampleW = 32;
  localparam int AmpW    = 31;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegPhaseStep = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWaveform  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFormat    = 2'd2;

  // Waveform register codes.
  localparam logic [1:0] WaveSquare = 2'd0;
  localparam logic [1:0] WaveSine   = 2'd1;
  localparam logic [1:0] WaveSilent = 2'd2;

  // Queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Fixed sample levels.
  localparam logic [SampleW-1:0] SampleMidU   = 32'h7FFF_FFFF;
  localparam logic [SampleW-1:0] SampleMaxS   = 32'h7FFF_FFFF;
  localparam logic [SampleW-1:0] SampleMinS   = 32'h8000_0000;
  localparam logic [SampleW-1:0] SampleMaxU   = 32'hFFFF_FFFF;
  localparam logic [SampleW-1:0] SampleZero   = 32'h0000_0000;

  // Q1.31 constants of the table builder.
  localparam logic [63:0] HalfPiQ31 = 64'd3373259426;
  localparam logic [63:0] OneQ31    = 64'd2147483648;
  localparam logic [63:0] AmpMax    = 64'd2147483647;
  localparam logic [63:0] RoundQ31  = 64'd1073741824;

  typedef logic [PhaseBits-1:0] phase_t;
  typedef logic [AmpW-1:0] amp_t;
  typedef amp_t sine_rom_t [SineDepth];

  // What the back end has to do with one item.
  typedef enum logic [1:0] {
    KindSquare,
    KindSine,
    KindMid
  } kind_e;

  // One classified sample tick.
  typedef struct packed {
    logic [SineAddrBits-1:0] addr;
    logic                    neg;
    kind_e                   kind;
    logic                    unsigned_fmt;
    logic                    last;
  } nco_item_t;

  // Quarter-wave table, sampled at the middle of each step, in Q1.31 with a
  // Horner-form Taylor series of the sine.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int k = 0; k < SineDepth; k++) begin
      x  = (HalfPiQ31 * (64'(2 * k) + 64'd1)) >> (SineAddrBits + 1);
      x2 = (x * x) >> 31;
      t  = OneQ31;
      t  = OneQ31 - (((x2 * t) >> 31) / 64'd156);
      t  = OneQ31 - (((x2 * t) >> 31) / 64'd110);
      t  = OneQ31 - (((x2 * t) >> 31) / 64'd72);
      t  = OneQ31 - (((x2 * t) >> 31) / 64'd42);
      t  = OneQ31 - (((x2 * t) >> 31) / 64'd20);
      t  = OneQ31 - (((x2 * t) >> 31) / 64'd6);
      s  = (x * t) >> 31;
      v  = (s * AmpMax + RoundQ31) >> 31;
      if (v > AmpMax) begin
        v = AmpMax;
      end
      rom[k] = v[AmpW-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

FILE: src/phase_accumulator_wave_generator.sv
// Top level of the phase-accumulator wave generator (numerically controlled oscillator).
// Every input transaction is one sample tick and yields exactly one 32-bit sample on the
// output stream, taken from the current phase before the phase step is added. While the
// output is not stalled, the block sustains one tick per clock cycle: the phase add in the
// front end and the single read port of the sine table in the back end each do their work
// once per cycle. An accepted tick is written into the queue; the table register and then
// the output register take it in turn. A two-entry queue keeps taking ticks while the
// output is stalled until it fills. The quarter-wave sine table (1024 entries of
// 31 bits) is a read-only memory built at elaboration, so no clearing pass follows reset.
// Configuration is written through the cfg channel, which is always ready. The user must
// write it only while no tick is in flight; the block itself does not enforce this. Index
// 0 phase step, 1 waveform (0 square, 1 sine, 2 or 3 silent), 2 sample format (0 signed,
// 1 offset binary).
module phase_accumulator_wave_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [nco_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nco_pkg::CfgDataW-1:0] cfg_data_i,
  // Sample tick stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [0] block_end, [7:1] zero
  // Sample stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [nco_pkg::SampleW-1:0]  m_axis_tdata_o,  // [31:0] sample
  output logic                         m_axis_tlast_o   // block_last
);
  import nco_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  nco_item_t front_item;
  nco_item_t queue_item;

  // Front end: accumulator and classification.
  nco_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (s_axis_tvalid_i),
    .tick_ready_o (s_axis_tready_o),
    .tick_last_i  (s_axis_tdata_i[0]),
    .push_o       (q_push),
    .item_o       (front_item),
    .full_i       (q_full)
  );

  // Decoupling queue.
  nco_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  // Back end: table read and formatting.
  nco_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .item_i       (queue_item),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_sample_o (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

  // The front never writes into a full queue.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue written while full");

  // The back never takes an item from an empty queue.
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue read while empty");

  // A new output sample always follows an earlier queue read.
  a_out_follows_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(q_pop, 2))
    else $error("output became valid without a table read");

endmodule

FILE: src/nco_front.sv
// Front end: configuration registers, phase accumulator and item classification.
module nco_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [nco_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nco_pkg::CfgDataW-1:0] cfg_data_i,
  // Sample tick input
  input  logic                      tick_valid_i,
  output logic                      tick_ready_o,
  input  logic                      tick_last_i,
  // Toward the queue
  output logic                      push_o,
  output nco_pkg::nco_item_t        item_o,
  input  logic                      full_i
);
  import nco_pkg::*;

  phase_t             phase_q, phase_d;
  logic [CfgDataW-1:0] step_q;
  logic [1:0]         wave_q;
  logic               fmt_q;
  logic [1:0]         quad;
  logic [SineAddrBits-1:0] idx;

  // Configuration registers are always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      wave_q <= WaveSilent;
      fmt_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPhaseStep: step_q <= cfg_data_i;
        RegWaveform:  wave_q <= cfg_data_i[1:0];
        RegFormat:    fmt_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A tick is taken whenever the queue has room.
  assign tick_ready_o = !full_i;
  assign push_o       = tick_valid_i && !full_i;

  // The accumulator advances once per accepted transaction and wraps.
  assign phase_d = phase_q + phase_t'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
    end
  end

  // Quadrant and table index; odd quadrants walk the table backward.
  assign quad = phase_q[PhaseBits-1 -: 2];
  assign idx  = phase_q[PhaseBits-3 -: SineAddrBits];

  always_comb begin
    item_o.addr         = quad[0] ? ~idx : idx;
    item_o.neg          = quad[1];
    item_o.unsigned_fmt = fmt_q;
    item_o.last         = tick_last_i;
    unique case (wave_q)
      WaveSquare: item_o.kind = KindSquare;
      WaveSine:   item_o.kind = KindSine;
      default:    item_o.kind = KindMid;
    endcase
  end

endmodule

FILE: src/nco_queue.sv
// Short queue of classified items between the front and the back end.
module nco_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  nco_pkg::nco_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output nco_pkg::nco_item_t item_o
);
  import nco_pkg::*;

  nco_item_t          mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   count_q;

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] n;
    n = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/nco_back.sv
// Back end: sine table read, sample formatting and the output register.
module nco_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // From the queue
  input  logic                         valid_i,
  input  nco_pkg::nco_item_t           item_i,
  output logic                         pop_o,
  // Sample output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [nco_pkg::SampleW-1:0]  out_sample_o,
  output logic                         out_last_o
);
  import nco_pkg::*;

  logic                 s1_valid_q;
  nco_item_t            s1_item_q;
  amp_t                 rom_q;
  logic                 out_valid_q;
  logic [SampleW-1:0]   out_sample_q;
  logic                 out_last_q;
  logic                 out_free;
  logic                 s1_free;
  logic                 s1_adv;
  logic [SampleW-1:0]   mag;
  logic [SampleW-1:0]   sample;

  // Stage handshakes: each stage moves when the one after it has room.
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_adv   = s1_valid_q && out_free;
  assign s1_free  = !s1_valid_q || out_free;
  assign pop_o    = valid_i && s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Table read with registered data, alongside the item.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rom_q     <= SineRom[item_i.addr];
      s1_item_q <= item_i;
    end
  end

  // Sample formatting.
  assign mag = {1'b0, rom_q};

  always_comb begin
    case (s1_item_q.kind)
      KindSquare: begin
        if (s1_item_q.unsigned_fmt) begin
          sample = s1_item_q.neg ? SampleZero : SampleMaxU;
        end else begin
          sample = s1_item_q.neg ? SampleMinS : SampleMaxS;
        end
      end
      KindSine: begin
        if (s1_item_q.unsigned_fmt) begin
          sample = s1_item_q.neg ? (SampleMidU - mag) : (SampleMidU + mag);
        end else begin
          sample = s1_item_q.neg ? (SampleZero - mag) : mag;
        end
      end
      default: begin
        sample = s1_item_q.unsigned_fmt ? SampleMidU : SampleZero;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_sample_q <= sample;
      out_last_q   <= s1_item_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;

endmodule
